// ===== hdl/m2cv_pkg.sv =====
`timescale 1ns / 1ps

package m2cv_pkg;

   localparam int OutputCount = 4;
   localparam int LampCount   = OutputCount - 1;
   localparam int CcTableSize = 128;
   localparam int PitchSize   = 60;
   localparam int PitchLow    = 11;
   localparam int PitchHigh   = 48;
   localparam logic [12:0] PitchMax = 13'd5000;

   typedef enum logic [2:0] {
      ModeControl   = 3'd0,
      ModeNoteOn    = 3'd1,
      ModeNoteOff   = 3'd2,
      ModeClock     = 3'd3,
      ModeTransport = 3'd4,
      ModeTick      = 3'd5
   } mode_type;

   typedef enum logic [2:0] {
      RegCcChannel    = 3'd0,
      RegCcController = 3'd1,
      RegNoteLow      = 3'd2,
      RegNoteHigh     = 3'd3,
      RegBaseNote     = 3'd4,
      RegClockDiv     = 3'd5,
      RegPulseLength  = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic [4:0]  midi_channel;
      logic [6:0]  data_first;
      logic [6:0]  data_second;
      logic [31:0] time_ms;
   } req_type;

   typedef struct packed {
      logic [12:0] cc_level_mv;
      logic [7:0]  cc_hue;
      logic [12:0] pitch_level_mv;
      logic        gate_high;
      logic        clock_high;
      logic [2:0]  lamp_mask;
   } rsp_type;

   typedef struct packed {
      logic [4:0] cc_midi_chan;
      logic [6:0] cc_controller_number;
      logic [2:0] note_channel_low;
      logic [2:0] note_channel_high;
      logic [6:0] base_note_number;
      logic [7:0] clock_division;
      logic [9:0] pulse_length_ms;
   } cfg_type;

   typedef struct packed {
      logic [7:0]                  total_held;
      logic [OutputCount-1:0][7:0] channel_held;
      logic [7:0]                  divide_count;
      logic                        pulse_active;
      logic [31:0]                 pulse_end_ms;
      logic [12:0]                 cc_level;
      logic [7:0]                  cc_hue;
      logic [12:0]                 pitch_level;
      logic                        gate;
      logic [LampCount-1:0]        lamp;
   } state_type;

   localparam cfg_type CfgReset = '{
      cc_midi_chan:         5'd1,
      cc_controller_number: 7'd1,
      note_channel_low:     3'd2,
      note_channel_high:    3'd4,
      base_note_number:     7'd60,
      clock_division:       8'd6,
      pulse_length_ms:      10'd10
   };

   typedef logic [12:0] cc_table_type [CcTableSize];
   typedef logic [12:0] pitch_table_type [PitchSize];

   function automatic cc_table_type build_cc_table();
      cc_table_type t;
      for (int i = 0; i < CcTableSize; i++) begin
         t[i] = 13'((i * 5000 + 63) / 127);
      end
      return t;
   endfunction

   function automatic pitch_table_type build_pitch_table();
      pitch_table_type t;
      int mv;
      for (int i = 0; i < PitchSize; i++) begin
         mv = (12000 + 1000 * (i - PitchLow) + 6) / 12;
         if (mv > 5000) begin
            mv = 5000;
         end
         t[i] = 13'(mv);
      end
      return t;
   endfunction

   localparam cc_table_type    CcTable    = build_cc_table();
   localparam pitch_table_type PitchTable = build_pitch_table();

endpackage

// ===== hdl/midi_to_cv_gate_clock.sv =====
`timescale 1ns / 1ps

// MIDI-to-CV/gate/clock converter.
// req_*: one decoded event or time tick per transfer (mode, channel, two data
//   bytes, millisecond time stamp).
// rsp_*: one result per request, carrying the CC level and hue, the shared
//   pitch level, gate, divided clock pulse and the note lamp mask after that event.
// csr_*: register writes, index 0..6; other indexes are dropped. csr_ready is
//   always high. Write only while no request is in flight.
// Path: a request is held in the request register, then its result in the result register.
// Throughput: one request per cycle while rsp_ready is high; the event update is a
//   single pass of logic between the request register and the result register.
// Reset: clears all counters, levels, the pulse and both pipeline stages, and
//   restores register defaults. No clearing sweep follows.
// Stall: while rsp_ready is low the result holds, the request register holds
//   one more item, and req_ready drops once both are full.
module midi_to_cv_gate_clock (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  m2cv_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output m2cv_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [9:0]        csr_data
);
   import m2cv_pkg::*;

   logic      in_valid_ff, in_valid_in;
   req_type   in_data_ff;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_data_ff, rsp_data_in;
   state_type state_ff, state_in;
   cfg_type   cfg_ff, cfg_in;
   logic      fire;
   logic      out_free;

   m2cv_update u_update (
      .state (state_ff),
      .item  (in_data_ff),
      .cfg   (cfg_ff),
      .next  (state_in)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || fire;
   assign csr_ready = 1'b1;

   assign in_valid_in  = req_ready ? req_valid : in_valid_ff;
   assign rsp_valid_in = fire ? 1'b1 : (out_free ? 1'b0 : rsp_valid_ff);

   assign rsp_data_in = '{
      cc_level_mv:    state_in.cc_level,
      cc_hue:         state_in.cc_hue,
      pitch_level_mv: state_in.pitch_level,
      gate_high:      state_in.gate,
      clock_high:     state_in.pulse_active,
      lamp_mask:      state_in.lamp
   };

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (reg_index_type'(csr_index))
            RegCcChannel:    cfg_in.cc_midi_chan         = csr_data[4:0];
            RegCcController: cfg_in.cc_controller_number = csr_data[6:0];
            RegNoteLow:      cfg_in.note_channel_low     = csr_data[2:0];
            RegNoteHigh:     cfg_in.note_channel_high    = csr_data[2:0];
            RegBaseNote:     cfg_in.base_note_number     = csr_data[6:0];
            RegClockDiv:     cfg_in.clock_division       = csr_data[7:0];
            RegPulseLength:  cfg_in.pulse_length_ms      = csr_data[9:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
         cfg_ff       <= CfgReset;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
         if (fire) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         in_data_ff <= req_data;
      end
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hdl/m2cv_update.sv =====
`timescale 1ns / 1ps

module m2cv_update (
   input  m2cv_pkg::state_type state,
   input  m2cv_pkg::req_type   item,
   input  m2cv_pkg::cfg_type   cfg,
   output m2cv_pkg::state_type next
);
   import m2cv_pkg::*;

   logic              note_ok;
   logic [1:0]        idx;
   logic signed [7:0] diff;
   logic [5:0]        pitch_sum;
   logic [12:0]       pitch_mv;
   logic [8:0]        div_next;
   logic [31:0]       time_gap;
   logic              note_on;
   logic              note_release;

   assign note_ok = (item.midi_channel >= {2'b00, cfg.note_channel_low})
                 && (item.midi_channel <= {2'b00, cfg.note_channel_high})
                 && (item.midi_channel >= 5'd1)
                 && (item.midi_channel <= 5'(OutputCount));
   assign idx = 2'(item.midi_channel - 5'd1);

   assign diff      = signed'({1'b0, item.data_first} - {1'b0, cfg.base_note_number});
   assign pitch_sum = 6'(diff + 8'sd11);

   always_comb begin
      if (diff < -8'sd11) begin
         pitch_mv = '0;
      end else if (diff > 8'sd48) begin
         pitch_mv = PitchMax;
      end else begin
         pitch_mv = PitchTable[pitch_sum];
      end
   end

   assign div_next = {1'b0, state.divide_count} + 9'd1;
   assign time_gap = item.time_ms - state.pulse_end_ms;

   assign note_on      = (mode_type'(item.mode) == ModeNoteOn) && (item.data_second != 7'd0);
   assign note_release = (mode_type'(item.mode) == ModeNoteOff)
                      || ((mode_type'(item.mode) == ModeNoteOn) && (item.data_second == 7'd0));

   always_comb begin
      next = state;
      unique case (mode_type'(item.mode))
         ModeControl: begin
            if (item.midi_channel == cfg.cc_midi_chan
                  && item.data_first == cfg.cc_controller_number) begin
               next.cc_level = CcTable[item.data_second];
               next.cc_hue   = {item.data_second, 1'b0};
            end
         end
         ModeNoteOn, ModeNoteOff: begin
            if (note_ok && note_on) begin
               if (state.total_held != 8'hFF) begin
                  next.total_held = state.total_held + 8'd1;
               end
               if (state.channel_held[idx] != 8'hFF) begin
                  next.channel_held[idx] = state.channel_held[idx] + 8'd1;
               end
               next.pitch_level = pitch_mv;
               next.gate        = 1'b1;
               if (idx != 2'd0) begin
                  next.lamp[2'(idx - 2'd1)] = 1'b1;
               end
            end else if (note_ok && note_release) begin
               if (state.total_held != 8'd0) begin
                  next.total_held = state.total_held - 8'd1;
               end
               if (state.channel_held[idx] != 8'd0) begin
                  next.channel_held[idx] = state.channel_held[idx] - 8'd1;
               end
               if (next.channel_held[idx] == 8'd0 && idx != 2'd0) begin
                  next.lamp[2'(idx - 2'd1)] = 1'b0;
               end
               if (next.total_held == 8'd0) begin
                  next.gate = 1'b0;
               end
            end
         end
         ModeClock: begin
            if (div_next < {1'b0, cfg.clock_division}) begin
               next.divide_count = div_next[7:0];
            end else begin
               next.divide_count = '0;
               next.pulse_active = 1'b1;
               next.pulse_end_ms = item.time_ms + {22'd0, cfg.pulse_length_ms};
            end
         end
         ModeTransport: begin
            next.divide_count = cfg.clock_division - 8'd1;
         end
         ModeTick: begin
            if (state.pulse_active && !time_gap[31]) begin
               next.pulse_active = 1'b0;
            end
         end
         default: begin
            next = state;
         end
      endcase
   end

endmodule

// ===== hdl/m2cv_checker.sv =====
`timescale 1ns / 1ps

module m2cv_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input m2cv_pkg::rsp_type rsp_data
);
   import m2cv_pkg::*;

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty result stage");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.cc_level_mv <= 13'd5000
                    && rsp_data.pitch_level_mv <= PitchMax
                    && !rsp_data.cc_hue[0])
      else $error("result level out of range");

endmodule

bind midi_to_cv_gate_clock m2cv_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
